@@ hw/rtl/scr2d_pkg.sv @@
// ----------------------------------------------------------------------------
// scr2d_pkg: shared types and constants for the staggered reconstruction block
// Holds register indexes, reset values and the front-to-back command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package scr2d_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_THETA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ODD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd3;

   localparam logic [9:0]  THETA_RST  = 10'd384;
   localparam logic [8:0]  WIDTH_RST  = 9'd256;
   localparam logic [15:0] HEIGHT_RST = 16'd256;

   // Classification of one accepted cell, handed from front to back
   typedef struct packed {
      logic        slope;   // slopes are formed for this cell
      logic        emit;    // a staggered result is produced
      logic        last;    // final result of the frame
      logic [7:0]  ocol;
      logic [15:0] orow;
   } cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/scr2d_front.sv @@
// ----------------------------------------------------------------------------
// scr2d_front: raster position tracking and cell classification
// Counts column and row, works out store addresses and the result position.
// ----------------------------------------------------------------------------
`default_nettype none

module scr2d_front #(
   parameter int MAX_WIDTH = scr2d_pkg::MAX_WIDTH_DEF,
   parameter int CW        = $clog2(MAX_WIDTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              restart,
   input  wire logic              step,
   input  wire logic              odd_grid,
   input  wire logic [8:0]        grid_width,
   input  wire logic [15:0]       grid_height,
   output scr2d_pkg::cmd_type     cmd,
   output logic [CW-1:0]          col,
   output logic [1:0]             row_cur,
   output logic [1:0]             row_p1,
   output logic [1:0]             row_p2
);

   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [1:0]    rmod_ff, rmod_in;
   logic [12:0]   w_eff;
   logic [15:0]   h_eff;
   logic [12:0]   c_ext;

   // effective geometry
   always_comb begin
      if (grid_width < 9'd5) w_eff = 13'd5;
      else if (13'(grid_width) > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
      else w_eff = 13'(grid_width);
      h_eff = (grid_height < 16'd5) ? 16'd5 : grid_height;
   end

   assign c_ext = 13'(col_ff);

   // counters
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      rmod_in = rmod_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         rmod_in = '0;
      end else if (step) begin
         if (c_ext + 13'd1 >= w_eff) begin
            col_in = '0;
            if (row_ff + 16'd1 >= h_eff) begin
               row_in  = '0;
               rmod_in = '0;
            end else begin
               row_in  = row_ff + 16'd1;
               rmod_in = (rmod_ff == 2'd2) ? 2'd0 : rmod_ff + 2'd1;
            end
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         rmod_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         rmod_ff <= rmod_in;
      end
   end

   // classification
   always_comb begin
      cmd.slope = (row_ff >= 16'd2) && (c_ext >= 13'd1) && (c_ext <= w_eff - 13'd2);
      cmd.emit  = cmd.slope && (row_ff >= 16'd3) && (c_ext >= 13'd2);
      cmd.last  = (c_ext == w_eff - 13'd2) && (row_ff == h_eff - 16'd1);
      cmd.ocol  = odd_grid ? 8'(c_ext - 13'd1) : 8'(c_ext);
      cmd.orow  = odd_grid ? row_ff - 16'd2 : row_ff - 16'd1;
   end

   assign col     = col_ff;
   assign row_cur = rmod_ff;
   assign row_p1  = (rmod_ff == 2'd0) ? 2'd2 : rmod_ff - 2'd1;
   assign row_p2  = (rmod_ff == 2'd2) ? 2'd0 : rmod_ff + 2'd1;

endmodule

`default_nettype wire

@@ hw/rtl/scr2d_back.sv @@
// ----------------------------------------------------------------------------
// scr2d_back: line stores, slope limiting and staggered averaging
// Pipeline: store read, difference, theta product, minmod, sum, output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scr2d_back #(
   parameter int MAX_WIDTH  = scr2d_pkg::MAX_WIDTH_DEF,
   parameter int DATA_WIDTH = scr2d_pkg::DATA_WIDTH_DEF,
   parameter int CW         = $clog2(MAX_WIDTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [31:0]           in_value,
   input  wire scr2d_pkg::cmd_type           in_cmd,
   input  wire logic [CW-1:0]                in_col,
   input  wire logic [1:0]                   in_rcur,
   input  wire logic [1:0]                   in_rp1,
   input  wire logic [1:0]                   in_rp2,
   input  wire logic [9:0]                   theta,
   output logic                              stall,
   output logic                              out_empty,
   input  wire logic                         out_pop,
   output logic signed [31:0]                out_value,
   output logic [7:0]                        out_col,
   output logic [15:0]                       out_row,
   output logic                              out_last
);

   localparam int DW = DATA_WIDTH;
   // difference times theta headroom, and room for the saturation bound
   localparam int EW = (DW + 1 > 44) ? DW + 1 : 44;
   // staggered sum plus quarter correction
   localparam int TW = (DW + 5 > 37) ? DW + 5 : 37;
   localparam int QD = 8;
   localparam int QCW = $clog2(QD + 1);
   localparam int PIPE = 5;

   // ---- line stores: one memory per row slot; row memories are read at this column and the next ----
   logic signed [31:0] row0_mem [MAX_WIDTH];
   logic signed [31:0] row1_mem [MAX_WIDTH];
   logic signed [31:0] row2_mem [MAX_WIDTH];
   logic signed [DW-1:0] xs_mem [MAX_WIDTH];
   logic signed [DW-1:0] zs_mem [MAX_WIDTH];

   // Neighbours needed: p1 at c-1, c, c+1 and p2 at c-1, c. The values at c
   // come from the store read at address c, and the p1 value for c+1 from a
   // second read at address c+1; the c-1 values of p1 and p2 are held in
   // registers from the previous valid cell.
   logic [CW-1:0]        rd_addr;
   logic signed [31:0]   r0_q, r1_q, r2_q;
   logic signed [DW-1:0] xs_q, zs_q;

   // stage 1 registers
   logic                 s1_v_ff;
   scr2d_pkg::cmd_type   s1_cmd_ff;
   logic signed [31:0]   s1_val_ff;
   logic [1:0]           s1_p1_ff, s1_p2_ff;
   logic [CW-1:0]        s1_col_ff;

   logic queue_room;
   logic adv;

   // The pipeline always advances; new cells are held off (stall) unless the
   // output queue has room for everything in flight plus one more.
   logic [QCW-1:0] q_cnt_ff, q_cnt_in;
   logic [$clog2(PIPE+1)-1:0] fly;
   assign queue_room = (32'(q_cnt_ff) + 32'(fly) < QD);
   assign adv   = 1'b1;
   assign stall = !queue_room;

   // Store write of the new cell; read of previous rows at this column
   assign rd_addr = in_col;

   always_ff @(posedge clock) begin
      if (in_valid) begin
         if (in_rcur == 2'd0) row0_mem[in_col] <= in_value;
         if (in_rcur == 2'd1) row1_mem[in_col] <= in_value;
         if (in_rcur == 2'd2) row2_mem[in_col] <= in_value;
      end
      r0_q <= row0_mem[rd_addr];
      r1_q <= row1_mem[rd_addr];
      r2_q <= row2_mem[rd_addr];
      xs_q <= xs_mem[rd_addr];
      zs_q <= zs_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else       s1_v_ff <= in_valid;
      s1_cmd_ff <= in_cmd;
      s1_val_ff <= in_value;
      s1_p1_ff  <= in_rp1;
      s1_p2_ff  <= in_rp2;
      s1_col_ff <= in_col;
   end

   // select rows p1, p2 for this column
   logic signed [31:0] p1_c, p2_c;
   always_comb begin
      case (s1_p1_ff)
         2'd0:    p1_c = r0_q;
         2'd1:    p1_c = r1_q;
         default: p1_c = r2_q;
      endcase
      case (s1_p2_ff)
         2'd0:    p2_c = r0_q;
         2'd1:    p2_c = r1_q;
         default: p2_c = r2_q;
      endcase
   end

   // Slopes for cell c need p1 at c+1, which was written a full row ago.
   // The x stencil is centred on column c: when column c arrives, window
   // (c-1,c,c+1) of row p1 is complete. The x slope at c uses p1[c-1..c+1],
   // read at arrival of c: c-1 from the previous-column tap, c from the
   // first read port and c+1 from a second fetch at address c+1, so the p1
   // values form a three-tap line.
   // Implementation: a second read port reads c+1 of the p1 row.
   logic signed [31:0] p1n_q;
   logic [CW-1:0]      nxt_addr;
   logic signed [31:0] p1n_sel;
   assign nxt_addr = in_col + CW'(1);
   logic signed [31:0] r0n_q, r1n_q, r2n_q;
   always_ff @(posedge clock) begin
      r0n_q <= row0_mem[nxt_addr];
      r1n_q <= row1_mem[nxt_addr];
      r2n_q <= row2_mem[nxt_addr];
   end
   always_comb begin
      case (s1_p1_ff)
         2'd0:    p1n_sel = r0n_q;
         2'd1:    p1n_sel = r1n_q;
         default: p1n_sel = r2n_q;
      endcase
   end
   assign p1n_q = p1n_sel;

   // previous-column taps (held only on valid cells)
   logic signed [31:0] p1_prev_ff, p2_prev_ff;
   always_ff @(posedge clock) begin
      if (s1_v_ff) begin
         p1_prev_ff <= p1_c;
         p2_prev_ff <= p2_c;
      end
   end

   // stage 2: differences
   logic                 s2_v_ff;
   scr2d_pkg::cmd_type   s2_cmd_ff;
   logic signed [33:0]   s2_xf_ff, s2_xc_ff, s2_xb_ff;
   logic signed [33:0]   s2_zf_ff, s2_zc_ff, s2_zb_ff;
   logic signed [33:0]   s2_sum_ff;
   logic signed [DW-1:0] s2_ox_ff, s2_oz_ff;
   logic [CW-1:0]        s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else       s2_v_ff <= s1_v_ff;
      s2_cmd_ff <= s1_cmd_ff;
      s2_col_ff <= s1_col_ff;
      s2_xf_ff  <= 34'(p1n_q) - 34'(p1_c);
      s2_xc_ff  <= 34'(p1n_q) - 34'(p1_prev_ff);
      s2_xb_ff  <= 34'(p1_c) - 34'(p1_prev_ff);
      s2_zf_ff  <= 34'(s1_val_ff) - 34'(p1_c);
      s2_zc_ff  <= 34'(s1_val_ff) - 34'(p2_c);
      s2_zb_ff  <= 34'(p1_c) - 34'(p2_c);
      s2_sum_ff <= 34'(p2_prev_ff) + 34'(p2_c) + 34'(p1_prev_ff) + 34'(p1_c);
      s2_ox_ff  <= xs_q;
      s2_oz_ff  <= zs_q;
   end

   // stage 3: theta products and half central difference
   logic                 s3_v_ff;
   scr2d_pkg::cmd_type   s3_cmd_ff;
   logic signed [EW-1:0] s3_xf_ff, s3_xc_ff, s3_xb_ff;
   logic signed [EW-1:0] s3_zf_ff, s3_zc_ff, s3_zb_ff;
   logic signed [33:0]   s3_sum_ff;
   logic signed [DW-1:0] s3_ox_ff, s3_oz_ff;
   logic [CW-1:0]        s3_col_ff;
   logic signed [10:0]   th_s;
   logic signed [EW-1:0] pxf, pxb, pzf, pzb;
   assign th_s = signed'({1'b0, theta});
   assign pxf = EW'(s2_xf_ff) * EW'(th_s);
   assign pxb = EW'(s2_xb_ff) * EW'(th_s);
   assign pzf = EW'(s2_zf_ff) * EW'(th_s);
   assign pzb = EW'(s2_zb_ff) * EW'(th_s);

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else       s3_v_ff <= s2_v_ff;
      s3_cmd_ff <= s2_cmd_ff;
      s3_col_ff <= s2_col_ff;
      s3_xf_ff  <= pxf >>> 8;
      s3_xb_ff  <= pxb >>> 8;
      s3_zf_ff  <= pzf >>> 8;
      s3_zb_ff  <= pzb >>> 8;
      s3_xc_ff  <= EW'(s2_xc_ff) >>> 1;
      s3_zc_ff  <= EW'(s2_zc_ff) >>> 1;
      s3_sum_ff <= s2_sum_ff;
      s3_ox_ff  <= s2_ox_ff;
      s3_oz_ff  <= s2_oz_ff;
   end

   // minmod with saturation
   function automatic logic signed [DW-1:0] mm3(input logic signed [EW-1:0] a,
                                                input logic signed [EW-1:0] b,
                                                input logic signed [EW-1:0] c);
      logic signed [EW-1:0] m;
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] lo;
      hi = EW'({1'b0, {(DW-1){1'b1}}});
      lo = -hi - EW'(1);
      m  = '0;
      if (a > 0 && b > 0 && c > 0) begin
         m = (a < b) ? a : b;
         m = (m < c) ? m : c;
      end else if (a < 0 && b < 0 && c < 0) begin
         m = (a > b) ? a : b;
         m = (m > c) ? m : c;
      end
      if (m > hi) m = hi;
      if (m < lo) m = lo;
      return DW'(m);
   endfunction

   // stage 4: limited slopes, slope store update and held slopes
   logic                 s4_v_ff;
   scr2d_pkg::cmd_type   s4_cmd_ff;
   logic signed [DW-1:0] s4_nx_ff, s4_nz_ff, s4_ox_ff, s4_oz_ff;
   logic signed [33:0]   s4_sum_ff;
   logic [CW-1:0]        s4_col_ff;

   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else       s4_v_ff <= s3_v_ff;
      s4_cmd_ff <= s3_cmd_ff;
      s4_col_ff <= s3_col_ff;
      s4_nx_ff  <= mm3(s3_xf_ff, s3_xc_ff, s3_xb_ff);
      s4_nz_ff  <= mm3(s3_zf_ff, s3_zc_ff, s3_zb_ff);
      s4_ox_ff  <= s3_ox_ff;
      s4_oz_ff  <= s3_oz_ff;
      s4_sum_ff <= s3_sum_ff;
   end

   logic signed [DW-1:0] hxa_ff, hza_ff, hxh_ff, hzh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         hxa_ff <= '0;
         hza_ff <= '0;
         hxh_ff <= '0;
         hzh_ff <= '0;
      end else if (s4_v_ff && s4_cmd_ff.slope) begin
         hxa_ff <= s4_ox_ff;
         hza_ff <= s4_oz_ff;
         hxh_ff <= s4_nx_ff;
         hzh_ff <= s4_nz_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_v_ff && s4_cmd_ff.slope) begin
         xs_mem[s4_col_ff] <= s4_nx_ff;
         zs_mem[s4_col_ff] <= s4_nz_ff;
      end
   end

   // stage 5: result
   logic signed [DW+2:0] corr;
   logic signed [TW-1:0] tot;
   assign corr = (DW+3)'(hxa_ff) - (DW+3)'(s4_ox_ff) + (DW+3)'(hxh_ff) - (DW+3)'(s4_nx_ff)
               + (DW+3)'(hza_ff) - (DW+3)'(hzh_ff) + (DW+3)'(s4_oz_ff) - (DW+3)'(s4_nz_ff);
   assign tot  = (TW'(s4_sum_ff) + TW'(corr >>> 2)) >>> 2;

   logic               s5_v_ff;
   logic signed [31:0] s5_val_ff;
   logic [7:0]         s5_col_ff;
   logic [15:0]        s5_row_ff;
   logic               s5_last_ff;
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else       s5_v_ff <= s4_v_ff && s4_cmd_ff.emit;
      s5_val_ff  <= 32'(tot);
      s5_col_ff  <= s4_cmd_ff.ocol;
      s5_row_ff  <= s4_cmd_ff.orow;
      s5_last_ff <= s4_cmd_ff.last;
   end

   assign fly = ($clog2(PIPE+1))'(s1_v_ff) + ($clog2(PIPE+1))'(s2_v_ff)
              + ($clog2(PIPE+1))'(s3_v_ff) + ($clog2(PIPE+1))'(s4_v_ff)
              + ($clog2(PIPE+1))'(s5_v_ff);

   // output queue
   localparam int QA = $clog2(QD);
   logic [31:0] qv_mem [QD];
   logic [7:0]  qc_mem [QD];
   logic [15:0] qr_mem [QD];
   logic        ql_mem [QD];
   logic [QA-1:0] wp_ff, rp_ff;
   logic push_q, pop_q;
   assign push_q = s5_v_ff;
   assign pop_q  = out_pop && (q_cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (push_q) begin
         qv_mem[wp_ff] <= s5_val_ff;
         qc_mem[wp_ff] <= s5_col_ff;
         qr_mem[wp_ff] <= s5_row_ff;
         ql_mem[wp_ff] <= s5_last_ff;
      end
   end

   always_comb begin
      q_cnt_in = q_cnt_ff;
      if (push_q && !pop_q) q_cnt_in = q_cnt_ff + QCW'(1);
      if (!push_q && pop_q) q_cnt_in = q_cnt_ff - QCW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (push_q) wp_ff <= wp_ff + QA'(1);
         if (pop_q)  rp_ff <= rp_ff + QA'(1);
         q_cnt_ff <= q_cnt_in;
      end
   end

   assign out_empty = (q_cnt_ff == '0) || !adv;
   assign out_value = qv_mem[rp_ff];
   assign out_col   = qc_mem[rp_ff];
   assign out_row   = qr_mem[rp_ff];
   assign out_last  = ql_mem[rp_ff];

endmodule

`default_nettype wire

@@ hw/rtl/staggered_central_reconstruction_2d.sv @@
// ----------------------------------------------------------------------------
// staggered_central_reconstruction_2d: minmod limited staggered reconstruction
//
// Cell averages enter in raster order on the req_ queue port (push/full),
// one per cycle while full is low. Each cell is classified by the front
// part (position, store slot, whether a result follows) and handed to the
// back part, a five-stage pipeline: store read, differences, theta
// products, minmod limiting with slope store update, and the staggered
// 2x2 sum. Results leave through an eight-entry queue on the rsp_ port
// (empty/pop).
// Throughput: one cell per cycle while the receiver keeps up; full rises
// once the result queue and the pipeline could not take another result.
// csr_ writes set theta, grid parity and geometry; a geometry write
// restarts the frame at cell (0,0). Reset clears counters, held slopes and
// the queue, and loads theta 384, odd grid, 256 x 256 geometry. The line
// stores are not cleared; within a frame every read follows its write.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_central_reconstruction_2d #(
   parameter int MAX_WIDTH  = scr2d_pkg::MAX_WIDTH_DEF,
   parameter int DATA_WIDTH = scr2d_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic signed [31:0]                req_cell_value,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic signed [31:0]                     rsp_staggered_value,
   output logic [7:0]                             rsp_out_column,
   output logic [15:0]                            rsp_out_row,
   output logic                                   rsp_last_of_frame,
   input  wire logic                              csr_write,
   input  wire logic [scr2d_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scr2d_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [9:0]  theta_ff;
   logic        odd_ff;
   logic [8:0]  width_ff;
   logic [15:0] height_ff;
   logic        restart;
   logic        stall;
   logic        step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         theta_ff  <= scr2d_pkg::THETA_RST;
         odd_ff    <= 1'b1;
         width_ff  <= scr2d_pkg::WIDTH_RST;
         height_ff <= scr2d_pkg::HEIGHT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            scr2d_pkg::CSR_THETA:  theta_ff  <= csr_data[9:0];
            scr2d_pkg::CSR_ODD:    odd_ff    <= csr_data[0];
            scr2d_pkg::CSR_WIDTH:  width_ff  <= csr_data[8:0];
            scr2d_pkg::CSR_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign restart = csr_write && (csr_index == scr2d_pkg::CSR_WIDTH ||
                                  csr_index == scr2d_pkg::CSR_HEIGHT);
   assign full = stall;
   assign step = push && !stall;

   scr2d_pkg::cmd_type cmd;
   logic [CW-1:0]      col;
   logic [1:0]         rcur, rp1, rp2;

   scr2d_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .step        (step),
      .odd_grid    (odd_ff),
      .grid_width  (width_ff),
      .grid_height (height_ff),
      .cmd         (cmd),
      .col         (col),
      .row_cur     (rcur),
      .row_p1      (rp1),
      .row_p2      (rp2)
   );

   scr2d_back #(.MAX_WIDTH(MAX_WIDTH), .DATA_WIDTH(DATA_WIDTH), .CW(CW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step),
      .in_value  (req_cell_value),
      .in_cmd    (cmd),
      .in_col    (col),
      .in_rcur   (rcur),
      .in_rp1    (rp1),
      .in_rp2    (rp2),
      .theta     (theta_ff),
      .stall     (stall),
      .out_empty (empty),
      .out_pop   (pop),
      .out_value (rsp_staggered_value),
      .out_col   (rsp_out_column),
      .out_row   (rsp_out_row),
      .out_last  (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

@@ verif/tb_staggered_central_reconstruction_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staggered_central_reconstruction_2d: self-checking bench for the block
// Streams frames of cell averages through the req_ queue port. A behavioural
// predictor of the minmod-limited staggered reconstruction computes each
// expected result when a cell transfers. The monitor compares every rsp_
// transfer with the oldest prediction, field by field. Geometry, theta and
// grid parity change between frames, while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_staggered_central_reconstruction_2d;

   localparam int MAXW = 256;

   typedef struct {
      logic signed [31:0] val;
      logic [7:0]         col;
      logic [15:0]        row;
      logic               last;
   } recon_type;

   logic clock;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic signed [31:0] req_cell_value = '0;
   logic signed [31:0] rsp_staggered_value;
   logic [7:0]  rsp_out_column;
   logic [15:0] rsp_out_row;
   logic        rsp_last_of_frame;
   logic        csr_write = 1'b0;
   logic [scr2d_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [scr2d_pkg::CSR_DATA_W-1:0] csr_data = '0;

   staggered_central_reconstruction_2d u_top (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_cell_value(req_cell_value),
      .empty(empty), .pop(pop),
      .rsp_staggered_value(rsp_staggered_value), .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row), .rsp_last_of_frame(rsp_last_of_frame),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state
   longint cell_rows [0:3*MAXW-1];
   longint xslopes [0:MAXW-1];
   longint zslopes [0:MAXW-1];
   int unsigned col_cnt, row_cnt;
   longint hx_above, hz_above, hx_here, hz_here;
   int unsigned theta_q8, odd_sel, width_reg, height_reg;

   logic signed [31:0] cell_queue [$];
   recon_type recon_queue [$];
   int     mismatches = 0;
   bit     quiet = 0;
   int     hold_ticket = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint minmod3(longint a, longint b, longint c);
      longint m;
      if (a > 0 && b > 0 && c > 0) begin
         m = a < b ? a : b;
         return m < c ? m : c;
      end
      if (a < 0 && b < 0 && c < 0) begin
         m = a > b ? a : b;
         return m > c ? m : c;
      end
      return 0;
   endfunction

   function automatic longint limit_slope(longint lo, longint mid, longint hi);
      longint th, s;
      th = longint'(theta_q8);
      s = minmod3(((hi - mid) * th) >>> 8, (hi - lo) >>> 1, ((mid - lo) * th) >>> 8);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s;
   endfunction

   // Advance the predictor by one cell; returns 1 when a result follows
   function automatic bit reconstruct_cell(input logic signed [31:0] val,
                                           output recon_type res);
      int unsigned w, h, c, r, cur, p1, p2;
      longint v, nx, nz, ox, oz, sum4, corr, acc;
      bit emit;
      emit = 0;
      res = '{default: '0};
      v = longint'(val);
      w = width_reg < 5 ? 5 : (width_reg > MAXW ? MAXW : width_reg);
      h = height_reg < 5 ? 5 : height_reg;
      c = col_cnt >= w ? 0 : col_cnt;
      r = row_cnt >= h ? 0 : row_cnt;
      cur = (r % 3) * MAXW;
      p1 = ((r + 2) % 3) * MAXW;
      p2 = ((r + 1) % 3) * MAXW;
      cell_rows[cur + c] = v;
      if (r >= 2 && c >= 1 && c <= w - 2) begin
         nx = limit_slope(cell_rows[p1 + c - 1], cell_rows[p1 + c], cell_rows[p1 + c + 1]);
         nz = limit_slope(cell_rows[p2 + c], cell_rows[p1 + c], v);
         ox = xslopes[c];
         oz = zslopes[c];
         if (r >= 3 && c >= 2) begin
            sum4 = cell_rows[p2 + c - 1] + cell_rows[p2 + c]
                 + cell_rows[p1 + c - 1] + cell_rows[p1 + c];
            corr = (hx_above - ox) + (hx_here - nx) + (hz_above - hz_here) + (oz - nz);
            acc = (sum4 + (corr >>> 2)) >>> 2;
            res.val = acc[31:0];
            res.col = odd_sel ? 8'(c - 1) : 8'(c);
            res.row = odd_sel ? 16'(r - 2) : 16'(r - 1);
            res.last = (c == w - 2 && r == h - 1);
            emit = 1;
         end
         hx_above = ox;
         hz_above = oz;
         hx_here = nx;
         hz_here = nz;
         xslopes[c] = nx;
         zslopes[c] = nz;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
      return emit;
   endfunction

   // Sender: transfer accounting, prediction and idle bursts
   int send_gap = 0;
   always @(posedge clock) begin
      recon_type res;
      bit nxt_push;
      logic signed [31:0] nxt_val;
      nxt_push = push;
      nxt_val = req_cell_value;
      if (push && !full) begin
         if (reconstruct_cell(req_cell_value, res)) recon_queue.push_back(res);
         nxt_push = 1'b0;
      end
      if (!nxt_push && !reset) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (cell_queue.size() > 0) begin
            if (!quiet && $urandom_range(0, 11) == 0) begin
               send_gap = $urandom_range(0, 7);
            end else begin
               nxt_push = 1'b1;
               nxt_val = cell_queue.pop_front();
            end
         end
      end
      push <= nxt_push;
      req_cell_value <= nxt_val;
   end

   // Receiver: checking, random stalls and the long hold-off
   int pop_gap = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      recon_type exp_r;
      if (pop && !empty) begin
         if (recon_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: val %h col %0d row %0d last %0d",
                        rsp_staggered_value, rsp_out_column, rsp_out_row,
                        rsp_last_of_frame);
         end else begin
            exp_r = recon_queue.pop_front();
            if (exp_r.val !== rsp_staggered_value || exp_r.col !== rsp_out_column ||
                exp_r.row !== rsp_out_row || exp_r.last !== rsp_last_of_frame) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp val %h col %0d row %0d last %0d,",
                            " got val %h col %0d row %0d last %0d"},
                           exp_r.val, exp_r.col, exp_r.row, exp_r.last,
                           rsp_staggered_value, rsp_out_column, rsp_out_row,
                           rsp_last_of_frame);
            end
         end
      end
      if (hold_seen != hold_ticket) begin
         hold_seen = hold_ticket;
         pop_gap = 300;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         pop_gap = $urandom_range(0, 7);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Wait until every cell has transferred and every result has arrived
   task automatic settle();
      wait (cell_queue.size() == 0 && !push);
      wait (recon_queue.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_put(logic [scr2d_pkg::CSR_IDX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[scr2d_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         scr2d_pkg::CSR_THETA: theta_q8 = value & 'h3FF;
         scr2d_pkg::CSR_ODD:   odd_sel = value & 1;
         scr2d_pkg::CSR_WIDTH: begin
            width_reg = value & 'h1FF;
            col_cnt = 0;
            row_cnt = 0;
         end
         scr2d_pkg::CSR_HEIGHT: begin
            height_reg = value & 'hFFFF;
            col_cnt = 0;
            row_cnt = 0;
         end
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned th, int unsigned odd, int unsigned w, int unsigned h);
      csr_put(scr2d_pkg::CSR_THETA, th);
      csr_put(scr2d_pkg::CSR_ODD, odd);
      csr_put(scr2d_pkg::CSR_WIDTH, w);
      csr_put(scr2d_pkg::CSR_HEIGHT, h);
   endtask

   // Mostly smooth fields so the limiter sees agreeing signs, some noise
   task automatic queue_cells(int unsigned w, int unsigned n);
      int a, b, k;
      logic signed [31:0] v;
      a = $urandom_range(0, 64) - 32;
      b = $urandom_range(0, 64) - 32;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: v = ((a * int'(k % w) + b * int'(k / w)) <<< 12)
                         + ($urandom_range(0, 8191) - 4096);
         endcase
         cell_queue.push_back(v);
      end
   endtask

   initial begin
      int k, w, h, n, done;
      int unsigned th;
      theta_q8 = scr2d_pkg::THETA_RST;
      odd_sel = 1;
      width_reg = scr2d_pkg::WIDTH_RST;
      height_reg = scr2d_pkg::HEIGHT_RST;
      col_cnt = 0;
      row_cnt = 0;
      hx_above = 0;
      hz_above = 0;
      hx_here = 0;
      hz_here = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: smallest grid, data extremes, theta at 512 (2.0)
      configure(512, 0, 5, 5);
      for (k = 0; k < 25; k++)
         case (k % 5)
            0: cell_queue.push_back(32'sh7FFFFFFF);
            1: cell_queue.push_back(32'sh80000000);
            2: cell_queue.push_back(32'sh0);
            3: cell_queue.push_back(32'(k) <<< 16);
            default: cell_queue.push_back(-(32'(k) <<< 16));
         endcase
      settle();

      // Width and height below the minimum are clamped to five
      configure(256, 1, 3, 2);
      queue_cells(5, 25);
      settle();

      // Whole frame with the receiver held off so the input stalls
      configure(384, 1, 24, 10);
      hold_ticket++;
      queue_cells(24, 240);
      settle();

      // Tall frame, left partial
      configure(1023, 0, 5, 65535);
      queue_cells(5, 60);
      settle();

      // Random frames; the last ones run with no idling
      done = 0;
      while (done < 200) begin
         w = $urandom_range(5, 12);
         h = $urandom_range(5, 9);
         case ($urandom_range(0, 5))
            0: th = 256;
            1: th = 512;
            2: th = $urandom_range(0, 1023);
            default: th = $urandom_range(256, 512);
         endcase
         case ($urandom_range(0, 3))
            0: n = $urandom_range(1, w * h - 1);
            1: n = 2 * w * h;
            default: n = w * h;
         endcase
         if (done > 130) quiet = 1;
         configure(th, $urandom_range(0, 1), w, h);
         queue_cells(w, n);
         done += n;
         settle();
      end

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
